// ===== rtl/core/dmds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmds_pkg: shared definitions for the dual motor drive sequencer
// Phase codes, command codes, register indexes, defaults and the lane
// status record passed from each motor lane to the merge stage.
// ----------------------------------------------------------------------------
package dmds_pkg;

   // Command codes carried in req_cmd
   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   // Register indexes on the csr port
   localparam logic [2:0] REG_NEUTRAL    = 3'd0;
   localparam logic [2:0] REG_MIN        = 3'd1;
   localparam logic [2:0] REG_MAX        = 3'd2;
   localparam logic [2:0] REG_DELTA      = 3'd3;
   localparam logic [2:0] REG_DEADBAND   = 3'd4;
   localparam logic [2:0] REG_FLAGS      = 3'd5;
   localparam logic [2:0] REG_BRAKE_PCT  = 3'd6;
   localparam logic [2:0] REG_BRAKE_MS   = 3'd7;

   // output_flags bit positions
   localparam int FLAG_REVERSE     = 0;
   localparam int FLAG_INV_LEFT    = 1;
   localparam int FLAG_INV_RIGHT   = 2;

   // Register reset values
   localparam logic [11:0] NEUTRAL_RESET   = 12'd1500;
   localparam logic [11:0] MIN_RESET       = 12'd1000;
   localparam logic [11:0] MAX_RESET       = 12'd2000;
   localparam logic [8:0]  DELTA_RESET     = 9'd400;
   localparam logic [8:0]  DELTA_LOW       = 9'd200;
   localparam logic [8:0]  DELTA_HIGH      = 9'd500;
   localparam logic [7:0]  DEADBAND_RESET  = 8'd40;
   localparam logic [2:0]  FLAGS_RESET     = 3'd3;
   localparam logic [6:0]  BRAKE_PCT_RESET = 7'd25;
   localparam logic [15:0] BRAKE_MS_RESET  = 16'd350;

   // Full drive and percent limits
   localparam logic signed [7:0] PCT_MAX = 8'sd100;
   localparam logic signed [7:0] PCT_MIN = -8'sd100;

   // Defaults of the top level parameters
   localparam int BOOST_PERCENT_DEF        = 40;
   localparam int BOOST_MS_DEF             = 180;
   localparam int MIN_MOVE_PERCENT_DEF     = 8;
   localparam int SLEW_PERCENT_PER_SEC_DEF = 250;
   localparam int PERIOD_MS_DEF            = 10;

   // Divide by 100: q = (m * DIV100_RECIP) >> DIV100_SHIFT, exact for m below 199000
   localparam int          DIV100_SHIFT = 24;
   localparam logic [17:0] DIV100_RECIP = 18'd167773;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_BOOST = 2'd1,
      PH_RUN   = 2'd2,
      PH_BRAKE = 2'd3
   } phase_type;

   typedef struct packed {
      logic signed [7:0] applied;
      phase_type         phase;
   } lane_status_type;

endpackage
`default_nettype wire

// ===== rtl/core/dual_motor_drive_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dual_motor_drive_sequencer: two-motor ESC drive sequencer
// Results: a tick's result is registered through the pipeline into the
// result register; requests update state and give no result.
// Throughput: one item per cycle unless the result register waits on rsp_ready;
// the pulse pipeline (two multipliers per lane) and req_ready hold only then.
// Reset: motor state, time and pipeline valid bits cleared, registers to defaults.
// ----------------------------------------------------------------------------
module dual_motor_drive_sequencer #(
   parameter int BOOST_PERCENT        = dmds_pkg::BOOST_PERCENT_DEF,
   parameter int BOOST_MS             = dmds_pkg::BOOST_MS_DEF,
   parameter int MIN_MOVE_PERCENT     = dmds_pkg::MIN_MOVE_PERCENT_DEF,
   parameter int SLEW_PERCENT_PER_SEC = dmds_pkg::SLEW_PERCENT_PER_SEC_DEF,
   parameter int PERIOD_MS            = dmds_pkg::PERIOD_MS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [2:0]        csr_index,
   input  wire logic [15:0]       csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_cmd,
   input  wire logic signed [7:0] req_left_target,
   input  wire logic signed [7:0] req_right_target,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [11:0]            rsp_left_pulse_us,
   output logic [11:0]            rsp_right_pulse_us,
   output logic signed [7:0]      rsp_left_applied,
   output logic signed [7:0]      rsp_right_applied,
   output logic [1:0]             rsp_left_phase,
   output logic [1:0]             rsp_right_phase
);

   localparam logic [31:0] PERIOD = 32'(PERIOD_MS);

   // configuration registers
   logic [11:0] neutral_ff, min_ff, max_ff;
   logic [8:0]  delta_ff, delta_sat;
   logic [7:0]  deadband_ff;
   logic [2:0]  flags_ff;
   logic [6:0]  brake_pct_ff;
   logic [15:0] brake_ms_ff;

   logic [31:0] time_ff, time_in;
   logic        advance, accept, tick;

   dmds_pkg::lane_status_type status_next [2];
   dmds_pkg::lane_status_type st1_ff [2];
   dmds_pkg::lane_status_type st2_ff [2];
   dmds_pkg::lane_status_type st3_ff [2];
   logic signed [7:0] pct_in [2];
   logic signed [7:0] pct1_ff [2];
   logic [1:0]        inv;
   logic [11:0]       pulse [2];
   logic              v1_ff, v2_ff, v3_ff, out_valid_ff;
   logic [11:0]       out_pulse_ff [2];
   dmds_pkg::lane_status_type out_st_ff [2];

   assign advance   = !(out_valid_ff && !rsp_ready);
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign tick      = accept && (req_cmd == dmds_pkg::CMD_TICK);
   assign time_in   = tick ? (time_ff + PERIOD) : time_ff;
   assign inv       = {flags_ff[dmds_pkg::FLAG_INV_RIGHT], flags_ff[dmds_pkg::FLAG_INV_LEFT]};

   always_comb begin
      delta_sat = csr_wdata[8:0];
      if (delta_sat < dmds_pkg::DELTA_LOW) delta_sat = dmds_pkg::DELTA_LOW;
      if (delta_sat > dmds_pkg::DELTA_HIGH) delta_sat = dmds_pkg::DELTA_HIGH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neutral_ff   <= dmds_pkg::NEUTRAL_RESET;
         min_ff       <= dmds_pkg::MIN_RESET;
         max_ff       <= dmds_pkg::MAX_RESET;
         delta_ff     <= dmds_pkg::DELTA_RESET;
         deadband_ff  <= dmds_pkg::DEADBAND_RESET;
         flags_ff     <= dmds_pkg::FLAGS_RESET;
         brake_pct_ff <= dmds_pkg::BRAKE_PCT_RESET;
         brake_ms_ff  <= dmds_pkg::BRAKE_MS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            dmds_pkg::REG_NEUTRAL:   neutral_ff   <= csr_wdata[11:0];
            dmds_pkg::REG_MIN:       min_ff       <= csr_wdata[11:0];
            dmds_pkg::REG_MAX:       max_ff       <= csr_wdata[11:0];
            dmds_pkg::REG_DELTA:     delta_ff     <= delta_sat;
            dmds_pkg::REG_DEADBAND:  deadband_ff  <= csr_wdata[7:0];
            dmds_pkg::REG_FLAGS:     flags_ff     <= csr_wdata[2:0];
            dmds_pkg::REG_BRAKE_PCT: brake_pct_ff <= csr_wdata[6:0];
            dmds_pkg::REG_BRAKE_MS:  brake_ms_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   dmds_lane #(
      .BOOST_PERCENT(BOOST_PERCENT), .BOOST_MS(BOOST_MS),
      .MIN_MOVE_PERCENT(MIN_MOVE_PERCENT),
      .SLEW_PERCENT_PER_SEC(SLEW_PERCENT_PER_SEC), .PERIOD_MS(PERIOD_MS)
   ) u_lane_left (
      .clock(clock), .reset(reset), .item_accept(accept), .item_cmd(req_cmd),
      .raw_target(req_left_target), .time_now(time_ff),
      .brake_percent(brake_pct_ff), .brake_ms(brake_ms_ff),
      .status_next(status_next[0])
   );

   dmds_lane #(
      .BOOST_PERCENT(BOOST_PERCENT), .BOOST_MS(BOOST_MS),
      .MIN_MOVE_PERCENT(MIN_MOVE_PERCENT),
      .SLEW_PERCENT_PER_SEC(SLEW_PERCENT_PER_SEC), .PERIOD_MS(PERIOD_MS)
   ) u_lane_right (
      .clock(clock), .reset(reset), .item_accept(accept), .item_cmd(req_cmd),
      .raw_target(req_right_target), .time_now(time_ff),
      .brake_percent(brake_pct_ff), .brake_ms(brake_ms_ff),
      .status_next(status_next[1])
   );

   // invert, then drop reverse drive when it is not allowed
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         pct_in[k] = inv[k] ? -status_next[k].applied : status_next[k].applied;
         if (!flags_ff[dmds_pkg::FLAG_REVERSE] && pct_in[k][7]) pct_in[k] = 8'sd0;
      end
   end

   dmds_pulse u_pulse_left (
      .clock(clock), .advance(advance), .pct(pct1_ff[0]),
      .neutral_us(neutral_ff), .min_us(min_ff), .max_us(max_ff),
      .delta_us(delta_ff), .deadband_us(deadband_ff), .pulse_us(pulse[0])
   );

   dmds_pulse u_pulse_right (
      .clock(clock), .advance(advance), .pct(pct1_ff[1]),
      .neutral_us(neutral_ff), .min_us(min_ff), .max_us(max_ff),
      .delta_us(delta_ff), .deadband_us(deadband_ff), .pulse_us(pulse[1])
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         time_ff <= time_in;
         // advance the whole pipeline unless the result register is held
         if (advance) begin
            v1_ff        <= tick;
            v2_ff        <= v1_ff;
            v3_ff        <= v2_ff;
            out_valid_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 2; k++) begin
            st1_ff[k]       <= status_next[k];
            pct1_ff[k]      <= pct_in[k];
            st2_ff[k]       <= st1_ff[k];
            st3_ff[k]       <= st2_ff[k];
            out_st_ff[k]    <= st3_ff[k];
            out_pulse_ff[k] <= pulse[k];
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_left_pulse_us  = out_pulse_ff[0];
   assign rsp_right_pulse_us = out_pulse_ff[1];
   assign rsp_left_applied   = out_st_ff[0].applied;
   assign rsp_right_applied  = out_st_ff[1].applied;
   assign rsp_left_phase     = out_st_ff[0].phase;
   assign rsp_right_phase    = out_st_ff[1].phase;

endmodule
`default_nettype wire

// ===== rtl/core/dmds_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmds_lane: one motor's sequencing state
// Holds target, applied percent, phase and phase end time; applies a
// request or a tick on each transfer and shows the post-update status.
// ----------------------------------------------------------------------------
module dmds_lane #(
   parameter int BOOST_PERCENT        = dmds_pkg::BOOST_PERCENT_DEF,
   parameter int BOOST_MS             = dmds_pkg::BOOST_MS_DEF,
   parameter int MIN_MOVE_PERCENT     = dmds_pkg::MIN_MOVE_PERCENT_DEF,
   parameter int SLEW_PERCENT_PER_SEC = dmds_pkg::SLEW_PERCENT_PER_SEC_DEF,
   parameter int PERIOD_MS            = dmds_pkg::PERIOD_MS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     item_accept,
   input  wire logic                     item_cmd,
   input  wire logic signed [7:0]        raw_target,
   input  wire logic [31:0]              time_now,
   input  wire logic [6:0]               brake_percent,
   input  wire logic [15:0]              brake_ms,
   output dmds_pkg::lane_status_type     status_next
);

   // Steps above 200 behave like 200 since results clamp at +-100
   localparam int STEP_RAW = (SLEW_PERCENT_PER_SEC * PERIOD_MS) / 1000;
   localparam int STEP_SAT = (STEP_RAW < 1) ? 1 : ((STEP_RAW > 200) ? 200 : STEP_RAW);
   localparam logic signed [9:0] STEP      = 10'(STEP_SAT);
   localparam logic signed [9:0] MIN_MOVE  = 10'(MIN_MOVE_PERCENT);
   localparam logic signed [7:0] BOOST_PCT = 8'(BOOST_PERCENT);
   localparam logic [31:0]       BOOST_LEN = 32'(BOOST_MS);

   logic signed [7:0]   target_ff, target_in;
   logic signed [7:0]   applied_ff, applied_in;
   dmds_pkg::phase_type phase_ff, phase_in;
   logic [31:0]         end_ff, end_in;

   logic signed [7:0] new_target;
   logic signed [7:0] new_mag;
   logic signed [7:0] brake_pct;
   logic signed [7:0] brake_applied;
   logic              old_pos, old_neg, new_pos, new_neg;
   logic signed [9:0] a_ext, t_ext, a_sum;

   always_comb begin
      // clamp the requested target to full drive
      if (raw_target > dmds_pkg::PCT_MAX) begin
         new_target = dmds_pkg::PCT_MAX;
      end else if (raw_target < dmds_pkg::PCT_MIN) begin
         new_target = dmds_pkg::PCT_MIN;
      end else begin
         new_target = raw_target;
      end
      new_mag = new_target[7] ? -new_target : new_target;
      old_pos = (applied_ff > 8'sd0);
      old_neg = applied_ff[7];
      new_pos = (new_target > 8'sd0);
      new_neg = new_target[7];
      brake_pct = (brake_percent > 7'd100) ? dmds_pkg::PCT_MAX : $signed({1'b0, brake_percent});
      brake_applied = old_pos ? -brake_pct : brake_pct;

      a_ext = {{2{applied_ff[7]}}, applied_ff};
      t_ext = {{2{target_ff[7]}}, target_ff};
      a_sum = a_ext;

      target_in  = target_ff;
      applied_in = applied_ff;
      phase_in   = phase_ff;
      end_in     = end_ff;

      if (item_accept && (item_cmd == dmds_pkg::CMD_REQUEST)) begin
         target_in = new_target;
         if ((old_pos || old_neg) && !(new_pos || new_neg)) begin
            phase_in   = dmds_pkg::PH_BRAKE;
            end_in     = time_now + 32'(brake_ms);
            applied_in = brake_applied;
         end else if (!(old_pos || old_neg) && (new_pos || new_neg) &&
                      (new_mag < BOOST_PCT)) begin
            phase_in   = dmds_pkg::PH_BOOST;
            end_in     = time_now + BOOST_LEN;
            applied_in = new_pos ? BOOST_PCT : -BOOST_PCT;
         end else if ((old_pos && new_neg) || (old_neg && new_pos)) begin
            // direction flip: half-length brake
            phase_in   = dmds_pkg::PH_BRAKE;
            end_in     = time_now + 32'(brake_ms >> 1);
            applied_in = brake_applied;
         end else begin
            phase_in = (new_pos || new_neg) ? dmds_pkg::PH_RUN : dmds_pkg::PH_IDLE;
         end
      end else if (item_accept) begin
         unique case (phase_ff)
            dmds_pkg::PH_IDLE: begin
               // decay toward zero, snap inside the small band
               if (a_ext > MIN_MOVE) begin
                  a_sum = a_ext - STEP;
                  if (a_sum < 10'sd0) a_sum = 10'sd0;
               end else if (a_ext < -MIN_MOVE) begin
                  a_sum = a_ext + STEP;
                  if (a_sum > 10'sd0) a_sum = 10'sd0;
               end else begin
                  a_sum = 10'sd0;
               end
               applied_in = a_sum[7:0];
            end
            dmds_pkg::PH_RUN: begin
               if (a_ext < t_ext) begin
                  a_sum = a_ext + STEP;
                  if (a_sum > t_ext) a_sum = t_ext;
               end else if (a_ext > t_ext) begin
                  a_sum = a_ext - STEP;
                  if (a_sum < t_ext) a_sum = t_ext;
               end
               applied_in = a_sum[7:0];
            end
            default: begin
               // timed phase ends once the counter reaches the end time
               if (time_now >= end_ff) begin
                  phase_in = (target_ff == 8'sd0) ? dmds_pkg::PH_IDLE : dmds_pkg::PH_RUN;
               end
            end
         endcase
      end

      status_next.applied = applied_in;
      status_next.phase   = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= '0;
         applied_ff <= '0;
         phase_ff   <= dmds_pkg::PH_IDLE;
         end_ff     <= '0;
      end else begin
         target_ff  <= target_in;
         applied_ff <= applied_in;
         phase_ff   <= phase_in;
         end_ff     <= end_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/dmds_pulse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmds_pulse: ESC pulse width pipeline for one lane
// Scales a drive percent by the full scale offset, divides by 100,
// applies the deadband snap and the min and max limits.
// ----------------------------------------------------------------------------
module dmds_pulse (
   input  wire logic               clock,
   input  wire logic               advance,
   input  wire logic signed [7:0]  pct,
   input  wire logic [11:0]        neutral_us,
   input  wire logic [11:0]        min_us,
   input  wire logic [11:0]        max_us,
   input  wire logic [8:0]         delta_us,
   input  wire logic [7:0]         deadband_us,
   output logic [11:0]             pulse_us
);

   localparam int QW = 16 + 18;

   logic signed [16:0] prod_ff, prod_in;
   logic [QW-1:0]      qprod_ff, qprod_in;
   logic               neg_ff, neg_in;
   logic [15:0]        mag;
   logic [8:0]         quot;
   logic signed [13:0] us;

   always_comb begin
      prod_in  = 17'(pct) * 17'($signed({1'b0, delta_us}));
      neg_in   = prod_ff[16];
      mag      = prod_ff[16] ? 16'(-prod_ff) : 16'(prod_ff);
      qprod_in = QW'(mag) * QW'(dmds_pkg::DIV100_RECIP);
      quot     = qprod_ff[dmds_pkg::DIV100_SHIFT +: 9];

      // |us - neutral| is the quotient itself
      if (quot <= {1'b0, deadband_us}) begin
         us = $signed({2'b00, neutral_us});
      end else if (neg_ff) begin
         us = $signed({2'b00, neutral_us}) - $signed({5'b00000, quot});
      end else begin
         us = $signed({2'b00, neutral_us}) + $signed({5'b00000, quot});
      end
      if (us < $signed({2'b00, min_us})) us = $signed({2'b00, min_us});
      if (us > $signed({2'b00, max_us})) us = $signed({2'b00, max_us});
      pulse_us = us[11:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= prod_in;
         neg_ff   <= neg_in;
         qprod_ff <= qprod_in;
      end
   end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the dual motor drive sequencer
// Drives request and tick transfers with random gaps and back-pressure,
// tracks both motors in a cycle-free model of their state, and checks every
// tick result field by field against the oldest predicted tick.
// ----------------------------------------------------------------------------
module testbench;

   localparam int HOLD_CYCLES   = 200;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 6;
   localparam int SLEW_STEP     =
      (dmds_pkg::SLEW_PERCENT_PER_SEC_DEF * dmds_pkg::PERIOD_MS_DEF / 1000 < 1) ? 1 :
      dmds_pkg::SLEW_PERCENT_PER_SEC_DEF * dmds_pkg::PERIOD_MS_DEF / 1000;

   typedef struct packed {
      logic [11:0]         left_pulse_us;
      logic [11:0]         right_pulse_us;
      logic signed [7:0]   left_applied;
      logic signed [7:0]   right_applied;
      dmds_pkg::phase_type left_phase;
      dmds_pkg::phase_type right_phase;
   } tick_result_type;

   class drive_tracker;
      int                  neutral, min_lim, max_lim, delta, deadband, brake_pct, brake_len;
      logic [2:0]          flags;
      logic [31:0]         now_ms;
      int                  target [2];
      int                  applied [2];
      dmds_pkg::phase_type phase [2];
      logic [31:0]         end_ms [2];
      tick_result_type     pending [$];
      int                  errors;

      function new();
         neutral   = int'(dmds_pkg::NEUTRAL_RESET);
         min_lim   = int'(dmds_pkg::MIN_RESET);
         max_lim   = int'(dmds_pkg::MAX_RESET);
         delta     = int'(dmds_pkg::DELTA_RESET);
         deadband  = int'(dmds_pkg::DEADBAND_RESET);
         flags     = dmds_pkg::FLAGS_RESET;
         brake_pct = int'(dmds_pkg::BRAKE_PCT_RESET);
         brake_len = int'(dmds_pkg::BRAKE_MS_RESET);
         now_ms    = '0;
         errors    = 0;
         for (int k = 0; k < 2; k++) begin
            target[k]  = 0;
            applied[k] = 0;
            phase[k]   = dmds_pkg::PH_IDLE;
            end_ms[k]  = '0;
         end
      endfunction

      function int clamp(int v, int lo, int hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function int sign_of(int v);
         if (v > 0) return 1;
         if (v < 0) return -1;
         return 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [15:0] value);
         int v;
         v = int'(value[8:0]);
         case (index)
            dmds_pkg::REG_NEUTRAL:   neutral = int'(value[11:0]);
            dmds_pkg::REG_MIN:       min_lim = int'(value[11:0]);
            dmds_pkg::REG_MAX:       max_lim = int'(value[11:0]);
            dmds_pkg::REG_DELTA:
               delta = clamp(v, int'(dmds_pkg::DELTA_LOW), int'(dmds_pkg::DELTA_HIGH));
            dmds_pkg::REG_DEADBAND:  deadband = int'(value[7:0]);
            dmds_pkg::REG_FLAGS:     flags = value[2:0];
            dmds_pkg::REG_BRAKE_PCT: brake_pct = int'(value[6:0]);
            dmds_pkg::REG_BRAKE_MS:  brake_len = int'(value);
            default: ;
         endcase
      endfunction

      function void retarget(int k, int raw);
         int nt, os, ns, bp, mag;
         nt  = clamp(raw, -100, 100);
         os  = sign_of(applied[k]);
         ns  = sign_of(nt);
         bp  = (brake_pct > 100) ? 100 : brake_pct;
         mag = (nt < 0) ? -nt : nt;
         target[k] = nt;
         if (os != 0 && nt == 0) begin
            phase[k]   = dmds_pkg::PH_BRAKE;
            end_ms[k]  = now_ms + 32'(brake_len);
            applied[k] = -os * bp;
         end else if (os == 0 && ns != 0 && mag < dmds_pkg::BOOST_PERCENT_DEF) begin
            phase[k]   = dmds_pkg::PH_BOOST;
            end_ms[k]  = now_ms + 32'(dmds_pkg::BOOST_MS_DEF);
            applied[k] = ns * dmds_pkg::BOOST_PERCENT_DEF;
         end else if (os != 0 && ns != 0 && os != ns) begin
            // direction flip: half-length brake
            phase[k]   = dmds_pkg::PH_BRAKE;
            end_ms[k]  = now_ms + 32'(brake_len / 2);
            applied[k] = -os * bp;
         end else begin
            phase[k] = (ns == 0) ? dmds_pkg::PH_IDLE : dmds_pkg::PH_RUN;
         end
      endfunction

      function void service(int k);
         int a, t;
         a = applied[k];
         t = target[k];
         case (phase[k])
            dmds_pkg::PH_IDLE: begin
               if (a > dmds_pkg::MIN_MOVE_PERCENT_DEF) begin
                  a -= SLEW_STEP;
                  if (a < 0) a = 0;
               end else if (a < -dmds_pkg::MIN_MOVE_PERCENT_DEF) begin
                  a += SLEW_STEP;
                  if (a > 0) a = 0;
               end else begin
                  a = 0;
               end
            end
            dmds_pkg::PH_RUN: begin
               if (a < t) begin
                  a += SLEW_STEP;
                  if (a > t) a = t;
               end else if (a > t) begin
                  a -= SLEW_STEP;
                  if (a < t) a = t;
               end
            end
            default: begin
               // timed phases hold applied until the end time passes
               if (now_ms >= end_ms[k])
                  phase[k] = (t == 0) ? dmds_pkg::PH_IDLE : dmds_pkg::PH_RUN;
            end
         endcase
         applied[k] = a;
      endfunction

      function logic [11:0] pulse_width(int pct, logic inv);
         int p, us, d;
         p = clamp(pct, -100, 100);
         if (inv) p = -p;
         if (!flags[dmds_pkg::FLAG_REVERSE]) p = clamp(p, 0, 100);
         us = neutral + (p * delta) / 100;
         d  = us - neutral;
         if (d < 0) d = -d;
         if (d <= deadband) us = neutral;
         if (us < min_lim) us = min_lim;
         if (us > max_lim) us = max_lim;
         return 12'(us);
      endfunction

      function void take_item(logic cmd, logic signed [7:0] left_raw,
                              logic signed [7:0] right_raw);
         tick_result_type r;
         if (cmd == dmds_pkg::CMD_REQUEST) begin
            retarget(0, int'(left_raw));
            retarget(1, int'(right_raw));
            return;
         end
         service(0);
         service(1);
         r.left_pulse_us  = pulse_width(applied[0], flags[dmds_pkg::FLAG_INV_LEFT]);
         r.right_pulse_us = pulse_width(applied[1], flags[dmds_pkg::FLAG_INV_RIGHT]);
         r.left_applied   = 8'(applied[0]);
         r.right_applied  = 8'(applied[1]);
         r.left_phase     = phase[0];
         r.right_phase    = phase[1];
         pending.push_back(r);
         now_ms += 32'(dmds_pkg::PERIOD_MS_DEF);
      endfunction

      function void compare_field(string name, int want, int seen);
         if (want != seen) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_tick(tick_result_type got);
         tick_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: tick result with none outstanding, expected nothing, actual %p",
                     $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("left_pulse_us", int'(want.left_pulse_us), int'(got.left_pulse_us));
         compare_field("right_pulse_us", int'(want.right_pulse_us), int'(got.right_pulse_us));
         compare_field("left_applied", int'(want.left_applied), int'(got.left_applied));
         compare_field("right_applied", int'(want.right_applied), int'(got.right_applied));
         compare_field("left_phase", int'(want.left_phase), int'(got.left_phase));
         compare_field("right_phase", int'(want.right_phase), int'(got.right_phase));
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [2:0]        csr_index;
   logic [15:0]       csr_wdata;
   logic              req_valid;
   logic              req_ready;
   logic              req_cmd;
   logic signed [7:0] req_left_target;
   logic signed [7:0] req_right_target;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [11:0]       rsp_left_pulse_us;
   logic [11:0]       rsp_right_pulse_us;
   logic signed [7:0] rsp_left_applied;
   logic signed [7:0] rsp_right_applied;
   logic [1:0]        rsp_left_phase;
   logic [1:0]        rsp_right_phase;

   drive_tracker    tracker;
   tick_result_type seen_tick;
   logic [15:0]     csr_plan [8];
   int              idle_pct = 36;
   int              hold_asked = 0;
   int              hold_done = 0;
   int              hold_left = 0;
   int              quiet_cycles = 0;
   int              phase_no;

   dual_motor_drive_sequencer uut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_left_target    (req_left_target),
      .req_right_target   (req_right_target),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_left_pulse_us  (rsp_left_pulse_us),
      .rsp_right_pulse_us (rsp_right_pulse_us),
      .rsp_left_applied   (rsp_left_applied),
      .rsp_right_applied  (rsp_right_applied),
      .rsp_left_phase     (rsp_left_phase),
      .rsp_right_phase    (rsp_right_phase)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_done != hold_asked) begin
         hold_done = hold_asked;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   // monitor both channels and watch for a stalled run
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen_tick.left_pulse_us  = rsp_left_pulse_us;
            seen_tick.right_pulse_us = rsp_right_pulse_us;
            seen_tick.left_applied   = rsp_left_applied;
            seen_tick.right_applied  = rsp_right_applied;
            seen_tick.left_phase     = dmds_pkg::phase_type'(rsp_left_phase);
            seen_tick.right_phase    = dmds_pkg::phase_type'(rsp_right_phase);
            tracker.check_tick(seen_tick);
         end
         if (req_valid && req_ready)
            tracker.take_item(req_cmd, req_left_target, req_right_target);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic send_item(logic cmd, logic signed [7:0] left_raw,
                            logic signed [7:0] right_raw);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_left_target  <= left_raw;
      req_right_target <= right_raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_ticks(int count);
      for (int i = 0; i < count; i++)
         send_item(dmds_pkg::CMD_TICK, 8'($urandom), 8'($urandom));
   endtask

   // drop valid, wait out every outstanding tick, then let the pipe empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_plan(int neutral, int min_us, int max_us, int delta, int deadband,
                           int flags, int brake_pct, int brake_len);
      csr_plan[dmds_pkg::REG_NEUTRAL]   = 16'(neutral);
      csr_plan[dmds_pkg::REG_MIN]       = 16'(min_us);
      csr_plan[dmds_pkg::REG_MAX]       = 16'(max_us);
      csr_plan[dmds_pkg::REG_DELTA]     = 16'(delta);
      csr_plan[dmds_pkg::REG_DEADBAND]  = 16'(deadband);
      csr_plan[dmds_pkg::REG_FLAGS]     = 16'(flags);
      csr_plan[dmds_pkg::REG_BRAKE_PCT] = 16'(brake_pct);
      csr_plan[dmds_pkg::REG_BRAKE_MS]  = 16'(brake_len);
   endtask

   task automatic program_csr();
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= csr_plan[i];
         @(posedge clock);
         tracker.write_reg(3'(i), csr_plan[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [7:0] pick_target();
      int mag;
      mag = 0;
      case ($urandom_range(0, 5))
         0: return 8'sd0;
         1: return 8'($urandom_range(0, 78) - 39);
         2: begin
            mag = $urandom_range(40, 100);
            return ($urandom_range(0, 1) != 0) ? 8'(mag) : 8'(-mag);
         end
         3: return 8'($urandom);
         4: return ($urandom_range(0, 1) != 0) ? 8'h7f : 8'h80;
         default: begin
            mag = $urandom_range(1, 8);
            return ($urandom_range(0, 1) != 0) ? 8'(mag) : 8'(-mag);
         end
      endcase
   endfunction

   // mostly a new target followed by a run of ticks; now and then a raw item
   task automatic run_traffic(int count);
      int done, run;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
            done++;
         end else begin
            send_item(dmds_pkg::CMD_REQUEST, pick_target(), pick_target());
            done++;
            run = $urandom_range(1, 40);
            for (int i = 0; i < run && done < count; i++) begin
               send_item(dmds_pkg::CMD_TICK, 8'($urandom), 8'($urandom));
               done++;
            end
         end
      end
   endtask

   initial begin
      tracker = new();
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      req_valid        <= 1'b0;
      req_cmd          <= dmds_pkg::CMD_REQUEST;
      req_left_target  <= '0;
      req_right_target <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: clamping, run, flip, stop, with a short brake
      set_plan(1500, 1000, 2000, 400, 40, 3, 25, 40);
      program_csr();
      send_ticks(1);
      send_item(dmds_pkg::CMD_REQUEST, 8'h7f, 8'h80);
      send_ticks(3);
      send_item(dmds_pkg::CMD_REQUEST, -8'sd50, 8'sd50);
      send_ticks(3);
      send_item(dmds_pkg::CMD_REQUEST, 8'sd0, 8'sd0);
      send_ticks(5);
      send_item(dmds_pkg::CMD_REQUEST, 8'sd20, -8'sd1);
      send_ticks(2);
      send_item(dmds_pkg::CMD_REQUEST, 8'sd101, -8'sd101);
      send_ticks(2);
      drain();

      // extremes: delta saturation, brake percent above 100, min above max
      set_plan(1500, 0, 4095, 0, 0, 0, 127, 0);
      program_csr();
      run_traffic(30);
      drain();
      set_plan(16'hffff, 3000, 1200, 16'hffff, 255, 7, 100, 65535);
      program_csr();
      run_traffic(30);
      drain();
      set_plan(0, 0, 4095, 500, 0, 6, 0, 1);
      program_csr();
      run_traffic(30);
      drain();

      for (phase_no = 0; phase_no < 4; phase_no++) begin
         set_plan({4'($urandom), 12'($urandom_range(1200, 1800))},
                  {4'($urandom), 12'($urandom_range(800, 1300))},
                  {4'($urandom), 12'($urandom_range(1700, 2300))},
                  16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom_range(0, 127), $urandom_range(0, 400));
         program_csr();
         idle_pct = (phase_no == 0) ? 0 : 36;
         if (phase_no == 1) begin
            // stall the result side long enough to back up the input
            run_traffic(20);
            hold_asked++;
            run_traffic(70);
         end else if (phase_no == 2) begin
            run_traffic(45);
            drain();
            run_traffic(45);
         end else begin
            run_traffic(90);
         end
         drain();
      end

      if (tracker.errors == 0 && tracker.outstanding() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/dmds_pkg.sv
rtl/core/dmds_lane.sv
rtl/core/dmds_pulse.sv
rtl/core/dual_motor_drive_sequencer.sv
tb/testbench.sv
